FILE: hdl/prls_pkg.sv
// ----------------------------------------------------------------------------
// prls_pkg
// Types and constants shared by the program read link sequencer files.
// ----------------------------------------------------------------------------
package prls_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_FAIL  = 2'd3;

    localparam logic [1:0] RK_FRAME  = 2'd0;
    localparam logic [1:0] RK_READ   = 2'd1;
    localparam logic [1:0] RK_DATA   = 2'd2;
    localparam logic [1:0] RK_FINISH = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_IDX  = 3'd1;
    localparam logic [2:0] ST_LINK     = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;

    localparam logic       CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic       CFG_POLL_LIMIT     = 1'b1;
    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h02;
    localparam logic [7:0] POLL_LIMIT_RST     = 8'd50;

    localparam logic [7:0] START_PAD    = 8'h00;
    localparam logic [7:0] START_CMD    = 8'h31;
    localparam logic [7:0] START_FLAG   = 8'h80;
    localparam logic [7:0] CHECK_BASE   = 8'hFF;
    localparam logic [7:0] MAX_INDEX    = 8'd3;
    localparam logic [7:0] READ_FLAG    = 8'h80;
    localparam logic [7:0] DATA_LEN_SEL = 8'h10;
    localparam logic [7:0] LB_STATUS    = READ_FLAG;
    localparam logic [7:0] LB_DATA      = READ_FLAG | DATA_LEN_SEL;
    localparam logic [5:0] STATUS_REPLY_LEN = 6'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_FIRST,
        PH_STATUS,
        PH_WAIT_POLL,
        PH_WAIT_READY,
        PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        J_START,
        J_FINISH,
        J_STATUS_REQ,
        J_DATA_REQ,
        J_RELEASE
    } t_job;

    typedef struct packed {
        t_job       kind;
        logic [1:0] index;
        logic [2:0] status;
        logic       final_pkt;
    } t_job_word;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] program_index;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] byte_value;
        logic [5:0] read_length;
        logic [2:0] status;
        logic       last;
    } t_out_word;

endpackage

FILE: hdl/prls_queue.sv
// ----------------------------------------------------------------------------
// prls_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module prls_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  prls_pkg::t_job_word i_job,
    input  logic                i_pop,
    output prls_pkg::t_job_word o_job,
    output logic                o_full,
    output logic                o_empty
);
    import prls_pkg::*;

    t_job_word                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]      r_wr_ptr;
    logic [QUEUE_AW-1:0]      r_rd_ptr;
    logic [QUEUE_AW:0]        r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");

endmodule

FILE: hdl/prls_front.sv
// ----------------------------------------------------------------------------
// prls_front
// Accepts input words, tracks the read run and issues jobs to the back end.
// ----------------------------------------------------------------------------
module prls_front #(
    parameter int PACKET_DATA_BYTES = 48,
    parameter int PACKET_COUNT      = 11,
    parameter int AW                = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  prls_pkg::t_in_word  i_in_word,
    input  logic [7:0]          i_poll_limit,
    input  logic                i_queue_full,
    input  logic                i_rel_done,
    output logic                o_job_valid,
    output prls_pkg::t_job_word o_job,
    output logic                o_buf_we,
    output logic [AW-1:0]       o_buf_addr,
    output logic [7:0]          o_buf_data
);
    import prls_pkg::*;

    localparam logic [5:0] DRL_LAST = 6'(PACKET_DATA_BYTES + 3);
    localparam logic [4:0] PKT_CNT  = 5'(PACKET_COUNT);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_polls_left, n_polls_left;
    logic [3:0]  r_packet_number, n_packet_number;
    logic [5:0]  r_count, n_count;
    logic [7:0]  r_sum, n_sum;
    logic        r_cw_busy, n_cw_busy;
    logic [3:0]  r_cw_pkt, n_cw_pkt;
    logic        r_rel_busy, n_rel_busy;

    logic        accept;
    logic        sum_ok;
    logic        last_pkt;
    logic [7:0]  rx;

    assign o_in_ready = !i_queue_full && !r_rel_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign rx         = i_in_word.rx_byte;
    assign sum_ok     = ((CHECK_BASE - r_sum) == rx);
    assign last_pkt   = ((5'(r_packet_number) + 5'd1) >= PKT_CNT);

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (i_in_word.opcode)
                OP_START: begin
                    n_phase = (i_in_word.program_index > MAX_INDEX) ? PH_IDLE : PH_WAIT_FIRST;
                end
                OP_BYTE: begin
                    if (r_phase == PH_STATUS && r_count >= 6'd3) begin
                        if (!sum_ok) begin
                            n_phase = PH_IDLE;
                        end else if (!r_cw_busy) begin
                            n_phase = PH_WAIT_READY;
                        end else if (r_polls_left <= 8'd1) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_WAIT_POLL;
                        end
                    end else if (r_phase == PH_DATA && r_count >= DRL_LAST) begin
                        if (!sum_ok || r_cw_pkt != r_packet_number || last_pkt) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_phase inside {PH_WAIT_FIRST, PH_WAIT_POLL}) begin
                        n_phase = PH_STATUS;
                    end else if (r_phase == PH_WAIT_READY) begin
                        n_phase = PH_DATA;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        n_polls_left    = r_polls_left;
        n_packet_number = r_packet_number;
        n_count         = r_count;
        n_sum           = r_sum;
        n_cw_busy       = r_cw_busy;
        n_cw_pkt        = r_cw_pkt;
        n_rel_busy      = r_rel_busy && !i_rel_done;
        o_job_valid     = 1'b0;
        o_job           = '{kind: J_FINISH, index: 2'd0, status: ST_OK, final_pkt: 1'b0};
        o_buf_we        = 1'b0;
        o_buf_addr      = AW'(r_count - 6'd3);
        o_buf_data      = rx;
        if (accept) begin
            case (i_in_word.opcode)
                OP_START: begin
                    o_job_valid = 1'b1;
                    if (i_in_word.program_index > MAX_INDEX) begin
                        o_job.status = ST_BAD_IDX;
                    end else begin
                        o_job.kind      = J_START;
                        o_job.index     = i_in_word.program_index[1:0];
                        n_polls_left    = i_poll_limit;
                        n_packet_number = '0;
                        n_count         = '0;
                        n_sum           = '0;
                        n_cw_busy       = 1'b0;
                        n_cw_pkt        = '0;
                    end
                end
                OP_BYTE: begin
                    if ((r_phase == PH_STATUS && r_count < 6'd3) ||
                        (r_phase == PH_DATA && r_count < DRL_LAST)) begin
                        n_sum   = r_sum + rx;
                        n_count = r_count + 6'd1;
                        if (r_count == 6'd1) begin
                            n_cw_pkt = rx[7:4];
                        end
                        if (r_count == 6'd2) begin
                            n_cw_busy = rx[7];
                        end
                        if (r_phase == PH_DATA && r_count >= 6'd3) begin
                            o_buf_we = 1'b1;
                        end
                    end else if (r_phase == PH_STATUS) begin
                        if (!sum_ok) begin
                            o_job_valid  = 1'b1;
                            o_job.status = ST_CHECKSUM;
                        end else if (!r_cw_busy) begin
                            n_packet_number = '0;
                        end else if (r_polls_left <= 8'd1) begin
                            n_polls_left = '0;
                            o_job_valid  = 1'b1;
                            o_job.status = ST_TIMEOUT;
                        end else begin
                            n_polls_left = r_polls_left - 8'd1;
                        end
                    end else if (r_phase == PH_DATA) begin
                        o_job_valid = 1'b1;
                        if (!sum_ok) begin
                            o_job.status = ST_CHECKSUM;
                        end else if (r_cw_pkt != r_packet_number) begin
                            o_job.status = ST_MISMATCH;
                        end else begin
                            o_job.kind      = J_RELEASE;
                            o_job.final_pkt = last_pkt;
                            n_rel_busy      = 1'b1;
                            if (!last_pkt) begin
                                n_packet_number = r_packet_number + 4'd1;
                                n_count         = '0;
                                n_sum           = '0;
                                n_cw_busy       = 1'b0;
                                n_cw_pkt        = '0;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (r_phase inside {PH_WAIT_FIRST, PH_WAIT_POLL, PH_WAIT_READY}) begin
                        o_job_valid = 1'b1;
                        o_job.kind  = (r_phase == PH_WAIT_READY) ? J_DATA_REQ : J_STATUS_REQ;
                        n_count     = '0;
                        n_sum       = '0;
                        n_cw_busy   = 1'b0;
                        n_cw_pkt    = '0;
                    end
                end
                default: begin
                    if (r_phase != PH_IDLE) begin
                        o_job_valid  = 1'b1;
                        o_job.status = ST_LINK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_polls_left    <= '0;
            r_packet_number <= '0;
            r_count         <= '0;
            r_sum           <= '0;
            r_cw_busy       <= 1'b0;
            r_cw_pkt        <= '0;
            r_rel_busy      <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_polls_left    <= n_polls_left;
            r_packet_number <= n_packet_number;
            r_count         <= n_count;
            r_sum           <= n_sum;
            r_cw_busy       <= n_cw_busy;
            r_cw_pkt        <= n_cw_pkt;
            r_rel_busy      <= n_rel_busy;
        end
    end

    a_no_write_during_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel_busy |-> !o_buf_we) else $error("packet buffer written during release");

endmodule

FILE: hdl/prls_back.sv
// ----------------------------------------------------------------------------
// prls_back
// Expands jobs into result words, holds the packet buffer and output register.
// ----------------------------------------------------------------------------
module prls_back #(
    parameter int PACKET_DATA_BYTES = 48,
    parameter int AW                = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_avail,
    input  prls_pkg::t_job_word i_job,
    output logic                o_job_pop,
    input  logic                i_buf_we,
    input  logic [AW-1:0]       i_buf_addr,
    input  logic [7:0]          i_buf_data,
    input  logic [6:0]          i_device_address,
    output logic                o_rel_done,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output prls_pkg::t_out_word o_out_word
);
    import prls_pkg::*;

    localparam int         SW       = $clog2(PACKET_DATA_BYTES + 4);
    localparam logic [SW-1:0] PDB   = SW'(PACKET_DATA_BYTES);
    localparam logic [SW-1:0] PDB_M1 = SW'(PACKET_DATA_BYTES - 1);
    localparam logic [5:0] DATA_REPLY_LEN = 6'(PACKET_DATA_BYTES + 4);

    logic [7:0]    r_mem [PACKET_DATA_BYTES];
    logic [7:0]    r_rd_data;
    logic          r_active;
    t_job_word     r_job;
    logic [SW-1:0] r_step;
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic          adv;
    logic          emit;
    logic          rd_en;
    logic [SW:0]   step_nxt;
    logic [AW-1:0] rd_addr;
    logic [1:0]    tail;
    logic [7:0]    addr_byte;
    logic [7:0]    mid;
    t_out_word     word;

    function automatic t_out_word req_word(input logic [1:0] idx, input logic [7:0] addr,
                                           input logic [7:0] lb, input logic [5:0] len);
        t_out_word w;
        w = '{result_kind: RK_FRAME, byte_value: 8'd0, read_length: 6'd0,
              status: ST_OK, last: 1'b0};
        case (idx)
            2'd0:    w.byte_value = addr;
            2'd1:    w.byte_value = lb;
            2'd2:    w.byte_value = CHECK_BASE - lb;
            default: begin
                w.result_kind = RK_READ;
                w.read_length = len;
                w.last        = 1'b1;
            end
        endcase
        return w;
    endfunction

    assign adv         = !r_out_valid || i_out_ready;
    assign emit        = r_active && adv;
    assign o_job_pop   = !r_active && i_job_avail;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_rel_done  = emit && r_job.kind == J_RELEASE && r_step == PDB_M1;
    assign step_nxt    = {1'b0, r_step} + 1'b1;
    assign rd_en       = o_job_pop || emit;
    assign rd_addr     = (o_job_pop || step_nxt >= (SW+1)'(PACKET_DATA_BYTES)) ? '0
                                                                             : AW'(step_nxt);
    assign tail        = 2'(r_step - PDB);
    assign addr_byte   = {1'b0, i_device_address};
    assign mid         = {2'b00, r_job.index, 4'b0000};

    always_comb begin
        word = '{result_kind: RK_FRAME, byte_value: 8'd0, read_length: 6'd0,
                 status: ST_OK, last: 1'b0};
        case (r_job.kind)
            J_START: begin
                case (r_step)
                    SW'(0):  word.byte_value = addr_byte;
                    SW'(1):  word.byte_value = START_PAD;
                    SW'(2):  word.byte_value = START_CMD;
                    SW'(3):  word.byte_value = mid;
                    SW'(4):  word.byte_value = START_FLAG;
                    default: begin
                        word.byte_value = CHECK_BASE - (START_PAD + START_CMD + mid + START_FLAG);
                        word.last       = 1'b1;
                    end
                endcase
            end
            J_STATUS_REQ: word = req_word(r_step[1:0], addr_byte, LB_STATUS, STATUS_REPLY_LEN);
            J_DATA_REQ:   word = req_word(r_step[1:0], addr_byte, LB_DATA, DATA_REPLY_LEN);
            J_RELEASE: begin
                if (r_step < PDB) begin
                    word.result_kind = RK_DATA;
                    word.byte_value  = r_rd_data;
                end else if (r_job.final_pkt) begin
                    word.result_kind = RK_FINISH;
                    word.last        = 1'b1;
                end else begin
                    word = req_word(tail, addr_byte, LB_DATA, DATA_REPLY_LEN);
                end
            end
            default: begin
                word.result_kind = RK_FINISH;
                word.status      = r_job.status;
                word.last        = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_active <= 1'b1;
            end else if (emit && word.last) begin
                r_active <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job  <= i_job;
            r_step <= '0;
        end else if (emit) begin
            r_step <= r_step + 1'b1;
        end
        if (emit) begin
            r_out_word <= word;
        end
        if (i_buf_we) begin
            r_mem[i_buf_addr] <= i_buf_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    a_done_in_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rel_done |-> (r_active && r_job.kind == J_RELEASE))
        else $error("release done outside a release job");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> r_active) else $error("job popped but back end not active");

endmodule

FILE: hdl/program_read_link_sequencer_unit.sv
// ----------------------------------------------------------------------------
// program_read_link_sequencer_unit
// Host-side sequencer that reads one stored program from a device over a
// byte link: start frame, status polls, packet reads with checksum checks.
// ----------------------------------------------------------------------------
// An input word is taken when the front end can accept it; it produces
// zero to 52 result words, one per cycle while the output is ready, from
// the back end once it has taken the job from the four-entry job queue. A
// released packet occupies the back end while its PACKET_DATA_BYTES data
// words and the trailing request frame or finish word are emitted, and input
// words stall until its data has been read out of the packet buffer, or while
// the job queue is full. No clearing pass is run after reset.
module program_read_link_sequencer_unit #(
    parameter int PACKET_DATA_BYTES = 48,
    parameter int PACKET_COUNT      = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  prls_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output prls_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import prls_pkg::*;

    localparam int AW = (PACKET_DATA_BYTES > 1) ? $clog2(PACKET_DATA_BYTES) : 1;

    logic [6:0]    r_device_address;
    logic [7:0]    r_poll_limit;
    logic          queue_full;
    logic          queue_empty;
    logic          job_valid;
    logic          job_pop;
    logic          rel_done;
    t_job_word     job_in;
    t_job_word     job_out;
    logic          buf_we;
    logic [AW-1:0] buf_addr;
    logic [7:0]    buf_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RST;
            r_poll_limit     <= POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data[6:0];
                CFG_POLL_LIMIT:     r_poll_limit     <= i_cfg_data;
                default:            r_poll_limit     <= r_poll_limit;
            endcase
        end
    end

    prls_front #(
        .PACKET_DATA_BYTES (PACKET_DATA_BYTES),
        .PACKET_COUNT      (PACKET_COUNT),
        .AW                (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_poll_limit (r_poll_limit),
        .i_queue_full (queue_full),
        .i_rel_done   (rel_done),
        .o_job_valid  (job_valid),
        .o_job        (job_in),
        .o_buf_we     (buf_we),
        .o_buf_addr   (buf_addr),
        .o_buf_data   (buf_data)
    );

    prls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    prls_back #(
        .PACKET_DATA_BYTES (PACKET_DATA_BYTES),
        .AW                (AW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_avail      (!queue_empty),
        .i_job            (job_out),
        .o_job_pop        (job_pop),
        .i_buf_we         (buf_we),
        .i_buf_addr       (buf_addr),
        .i_buf_data       (buf_data),
        .i_device_address (r_device_address),
        .o_rel_done       (rel_done),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_word       (o_out_word)
    );

endmodule
